@@ design/mfd_pkg.sv @@
package mfd_pkg;

  localparam logic [7:0] StartV1  = 8'hFE;
  localparam logic [7:0] StartV2  = 8'hFD;
  localparam logic [3:0] SigBytes = 4'd13;

  localparam logic [1:0] VerV1 = 2'd1;
  localparam logic [1:0] VerV2 = 2'd2;

  localparam logic KindPayload = 1'b0;
  localparam logic KindFrame   = 1'b1;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic        kind;
    logic [1:0]  version;
    logic [7:0]  payload_len;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [23:0] msg_id;
    logic [7:0]  byte_index;
    logic [7:0]  payload_byte;
  } rec_t;

endpackage

@@ design/mavlink_frame_deframer.sv @@
// MAVLink v1/v2 frame deframer.
// Input channel: one received byte per request on data_byte_i, qualified by
// in_valid_i; the block holds in_stall_o high while its result queue is full.
// Output channel: one result per request on out_valid_o / out_stall_i.
// kind_o = 0 is a payload byte (byte_index_o, payload_byte_o), kind_o = 1
// marks frame completion, with the header fields on version_o, payload_len_o,
// sys_id_o, comp_id_o and msg_id_o. Checksum and signature bytes give no
// result, but the last byte of a frame gives the frame completion.
// Throughput: one byte per cycle; the parser takes a byte every cycle the
// queue has room. A result is written to the queue when its byte is accepted,
// then loads into the output register once that register is empty or taken.
// When the receiver stalls, the output register holds its result, the queue
// (QueueDepth entries) fills, and then in_stall_o rises until space frees.
// Reset puts the parser in idle waiting for a start byte, clears the header
// capture and empties the queue and output register.
module mavlink_frame_deframer #(
  parameter int unsigned QueueDepth = mfd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [1:0]  version_o,
  output logic [7:0]  payload_len_o,
  output logic [7:0]  sys_id_o,
  output logic [7:0]  comp_id_o,
  output logic [23:0] msg_id_o,
  output logic [7:0]  byte_index_o,
  output logic [7:0]  payload_byte_o
);

  logic          q_full, q_valid, q_pop, push;
  mfd_pkg::rec_t push_rec, q_rec, out_rec;

  mfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  mfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_rec_o  (q_rec),
    .pop_i      (q_pop)
  );

  mfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec)
  );

  assign kind_o         = out_rec.kind;
  assign version_o      = out_rec.version;
  assign payload_len_o  = out_rec.payload_len;
  assign sys_id_o       = out_rec.sys_id;
  assign comp_id_o      = out_rec.comp_id;
  assign msg_id_o       = out_rec.msg_id;
  assign byte_index_o   = out_rec.byte_index;
  assign payload_byte_o = out_rec.payload_byte;

endmodule

@@ design/mfd_front.sv @@
module mfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output mfd_pkg::rec_t rec_o
);

  typedef enum logic [4:0] {
    PhIdle,
    Ph1Len, Ph1Seq, Ph1Sys, Ph1Comp, Ph1Id, Ph1Pay, Ph1Ck1, Ph1Ck2,
    Ph2Len, Ph2Incf, Ph2Compf, Ph2Seq, Ph2Sys, Ph2Comp,
    Ph2Id0, Ph2Id1, Ph2Id2, Ph2Pay, Ph2Ck1, Ph2Ck2, Ph2Sig
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  ver_q, ver_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        signed_q, signed_d;
  logic [3:0]  sig_rem_q, sig_rem_d;
  logic [7:0]  sys_q, sys_d;
  logic [7:0]  comp_q, comp_d;
  logic [23:0] msg_q, msg_d;
  logic        accept;
  logic [7:0]  cnt_inc;
  logic [3:0]  sig_dec;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign cnt_inc    = cnt_q + 8'd1;
  assign sig_dec    = sig_rem_q - 4'd1;

  always_comb begin
    phase_d    = phase_q;
    ver_d      = ver_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    signed_d   = signed_q;
    sig_rem_d  = sig_rem_q;
    sys_d      = sys_q;
    comp_d     = comp_q;
    msg_d      = msg_q;
    push_o     = 1'b0;

    rec_o.kind         = mfd_pkg::KindFrame;
    rec_o.version      = ver_q;
    rec_o.payload_len  = len_q;
    rec_o.sys_id       = sys_q;
    rec_o.comp_id      = comp_q;
    rec_o.msg_id       = msg_q;
    rec_o.byte_index   = '0;
    rec_o.payload_byte = '0;

    if (accept) begin
      unique case (phase_q)
        PhIdle: begin
          if (data_byte_i == mfd_pkg::StartV1 || data_byte_i == mfd_pkg::StartV2) begin
            ver_d      = (data_byte_i == mfd_pkg::StartV1) ? mfd_pkg::VerV1 : mfd_pkg::VerV2;
            phase_d    = (data_byte_i == mfd_pkg::StartV1) ? Ph1Len : Ph2Len;
            len_d      = '0;
            cnt_d      = '0;
            signed_d   = 1'b0;
            sig_rem_d  = '0;
            sys_d      = '0;
            comp_d     = '0;
            msg_d      = '0;
          end
        end
        Ph1Len: begin
          len_d   = data_byte_i;
          cnt_d   = '0;
          phase_d = Ph1Seq;
        end
        Ph1Seq:  phase_d = Ph1Sys;
        Ph1Sys: begin
          sys_d   = data_byte_i;
          phase_d = Ph1Comp;
        end
        Ph1Comp: begin
          comp_d  = data_byte_i;
          phase_d = Ph1Id;
        end
        Ph1Id: begin
          msg_d   = {16'd0, data_byte_i};
          phase_d = (len_q != 8'd0) ? Ph1Pay : Ph1Ck1;
        end
        Ph1Pay, Ph2Pay: begin
          push_o             = 1'b1;
          rec_o.kind         = mfd_pkg::KindPayload;
          rec_o.byte_index   = cnt_q;
          rec_o.payload_byte = data_byte_i;
          cnt_d              = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = (phase_q == Ph1Pay) ? Ph1Ck1 : Ph2Ck1;
          end
        end
        Ph1Ck1:  phase_d = Ph1Ck2;
        Ph1Ck2: begin
          push_o  = 1'b1;
          phase_d = PhIdle;
        end
        Ph2Len: begin
          len_d   = data_byte_i;
          phase_d = Ph2Incf;
        end
        Ph2Incf: begin
          signed_d = data_byte_i[0];
          phase_d  = Ph2Compf;
        end
        Ph2Compf: phase_d = Ph2Seq;
        Ph2Seq:   phase_d = Ph2Sys;
        Ph2Sys: begin
          sys_d   = data_byte_i;
          phase_d = Ph2Comp;
        end
        Ph2Comp: begin
          comp_d  = data_byte_i;
          phase_d = Ph2Id0;
        end
        Ph2Id0: begin
          msg_d   = {16'd0, data_byte_i};
          phase_d = Ph2Id1;
        end
        Ph2Id1: begin
          msg_d   = msg_q | {8'd0, data_byte_i, 8'd0};
          phase_d = Ph2Id2;
        end
        Ph2Id2: begin
          msg_d   = msg_q | {data_byte_i, 16'd0};
          cnt_d   = '0;
          phase_d = (len_q != 8'd0) ? Ph2Pay : Ph2Ck1;
        end
        Ph2Ck1: phase_d = Ph2Ck2;
        Ph2Ck2: begin
          if (signed_q) begin
            sig_rem_d = mfd_pkg::SigBytes;
            phase_d   = Ph2Sig;
          end else begin
            push_o  = 1'b1;
            phase_d = PhIdle;
          end
        end
        Ph2Sig: begin
          sig_rem_d = sig_dec;
          if (sig_dec == 4'd0) begin
            push_o  = 1'b1;
            phase_d = PhIdle;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      ver_q      <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      signed_q   <= 1'b0;
      sig_rem_q  <= '0;
      sys_q      <= '0;
      comp_q     <= '0;
      msg_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      ver_q      <= ver_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      signed_q   <= signed_d;
      sig_rem_q  <= sig_rem_d;
      sys_q      <= sys_d;
      comp_q     <= comp_d;
      msg_q      <= msg_d;
    end
  end

endmodule

@@ design/mfd_queue.sv @@
module mfd_queue #(
  parameter int unsigned Depth = mfd_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfd_pkg::rec_t push_rec_i,
  output logic          full_o,
  output logic          valid_o,
  output mfd_pkg::rec_t pop_rec_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mfd_pkg::rec_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_rec_o = mem_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

@@ design/mfd_back.sv @@
module mfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mfd_pkg::rec_t q_rec_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mfd_pkg::rec_t out_rec_o
);

  logic          valid_q, valid_d;
  mfd_pkg::rec_t rec_q;
  logic          load;

  // refill the output register when it is empty or being taken
  assign load    = q_valid_i & (~valid_q | ~out_stall_i);
  assign q_pop_o = load;
  assign valid_d = load | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= q_rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;

endmodule
